// File: rtl/ksc_pkg.sv
// Package for the key scanner: item structs, request/answer/event codes,
// register map and word layout constants. Depends on nothing.
package ksc_pkg;

   localparam int NUM_PINS   = 8;
   localparam int NUM_GROUPS = 4;
   localparam int GROUP_BASE = 8;
   localparam int WORD_W     = 12;
   localparam int TIME_W     = 16;
   localparam int RUN_W      = 8;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [RUN_W-1:0] DEBOUNCE_RESET = RUN_W'(5);

   localparam logic [1:0] REQ_SCAN      = 2'd0;
   localparam logic [1:0] REQ_QUERY     = 2'd1;
   localparam logic [1:0] REQ_MASK      = 2'd2;
   localparam logic [1:0] REQ_RECAPTURE = 2'd3;

   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_DOWN   = 2'd1;
   localparam logic [1:0] ACT_UP     = 2'd2;
   localparam logic [1:0] ACT_REPEAT = 2'd3;

   localparam logic [1:0] EV_NONE   = 2'd0;
   localparam logic [1:0] EV_CHANGE = 2'd1;
   localparam logic [1:0] EV_HOLD   = 2'd2;

   localparam logic [2:0] REG_COMBO_0  = 3'd0;
   localparam logic [2:0] REG_COMBO_1  = 3'd1;
   localparam logic [2:0] REG_COMBO_2  = 3'd2;
   localparam logic [2:0] REG_COMBO_3  = 3'd3;
   localparam logic [2:0] REG_DEBOUNCE = 3'd4;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [7:0]        pin_bits;
      logic [TIME_W-1:0] timestamp_ms;
      logic [WORD_W-1:0] key_mask;
      logic              no_repeat;
      logic [TIME_W-1:0] first_delay_ms;
      logic [TIME_W-1:0] repeat_ms;
   } scan_req_type;

   typedef struct packed {
      logic [1:0]        key_action;
      logic [1:0]        scan_event;
      logic [WORD_W-1:0] key_state;
   } scan_rsp_type;

endpackage

// File: rtl/key_scanner_with_combo_and_repeat_unit.sv
// Top level of the eight-key scanner with debounce, combos and auto-repeat.
// Depends on ksc_pkg for the item structs, codes and register map.
//
// The block takes one item per clock cycle while req_stall is low and gives
// exactly one result item for each; the whole update of the key state
// is a single registered pass. A result register backed by one skid entry lets
// the block keep accepting while a result waits, and req_stall rises only when
// both hold results. Configuration sits on an APB-style port: combo masks at
// byte addresses 0x0 to 0xC and the debounce count (reset 5) at 0x10.
module key_scanner_with_combo_and_repeat_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ksc_pkg::scan_req_type             req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ksc_pkg::scan_rsp_type             rsp_item,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ksc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ksc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ksc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import ksc_pkg::*;

   logic [NUM_PINS-1:0] combo_ff [NUM_GROUPS];
   logic [RUN_W-1:0]    debounce_ff;

   logic [WORD_W-1:0] accepted_ff, accepted_in;
   logic [WORD_W-1:0] changed_ff, changed_in;
   logic [WORD_W-1:0] current_ff, current_in;
   logic [WORD_W-1:0] masked_ff, masked_in;
   logic [WORD_W-1:0] repeating_ff, repeating_in;
   logic [TIME_W-1:0] first_ff, first_in;
   logic [TIME_W-1:0] repeat_ff, repeat_in;
   logic [TIME_W-1:0] prev_tick_ff, prev_tick_in;
   logic [RUN_W-1:0]  change_run_ff, change_run_in;
   logic [RUN_W-1:0]  hold_run_ff, hold_run_in;

   scan_rsp_type out_ff, out_in, skid_ff, skid_in;
   logic         out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   scan_rsp_type      result;
   logic              accept, take;
   logic [2:0]        cfg_index;
   logic [TIME_W-1:0] diff;
   logic [WORD_W-1:0] pins, word, k;
   logic              matched;
   logic [RUN_W-1:0]  run_next;

   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;
   assign pready    = 1'b1;
   assign cfg_index = paddr[4:2];

   always_comb begin
      prdata = '0;
      case (cfg_index)
         REG_COMBO_0:  prdata = CSR_DATA_W'(combo_ff[0]);
         REG_COMBO_1:  prdata = CSR_DATA_W'(combo_ff[1]);
         REG_COMBO_2:  prdata = CSR_DATA_W'(combo_ff[2]);
         REG_COMBO_3:  prdata = CSR_DATA_W'(combo_ff[3]);
         REG_DEBOUNCE: prdata = CSR_DATA_W'(debounce_ff);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            combo_ff[g] <= '0;
         end
         debounce_ff <= DEBOUNCE_RESET;
      end else if (psel && penable && pwrite) begin
         case (cfg_index)
            REG_COMBO_0:  combo_ff[0] <= pwdata[NUM_PINS-1:0];
            REG_COMBO_1:  combo_ff[1] <= pwdata[NUM_PINS-1:0];
            REG_COMBO_2:  combo_ff[2] <= pwdata[NUM_PINS-1:0];
            REG_COMBO_3:  combo_ff[3] <= pwdata[NUM_PINS-1:0];
            REG_DEBOUNCE: debounce_ff <= pwdata[RUN_W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      accepted_in   = accepted_ff;
      changed_in    = changed_ff;
      current_in    = current_ff;
      masked_in     = masked_ff;
      repeating_in  = repeating_ff;
      first_in      = first_ff;
      repeat_in     = repeat_ff;
      prev_tick_in  = prev_tick_ff;
      change_run_in = change_run_ff;
      hold_run_in   = hold_run_ff;
      result        = '0;
      matched       = 1'b0;
      run_next      = '0;
      k             = req_item.key_mask;
      pins          = WORD_W'(req_item.pin_bits[NUM_PINS-1:0]);
      word          = pins;
      diff          = req_item.timestamp_ms - prev_tick_ff;

      case (req_item.req_type)
         REQ_SCAN: begin
            prev_tick_in = req_item.timestamp_ms;
            first_in     = (first_ff >= diff) ? first_ff - diff : '0;
            repeat_in    = (repeat_ff >= diff) ? repeat_ff - diff : '0;
            for (int g = 0; g < NUM_GROUPS; g++) begin
               if (!matched && combo_ff[g] != '0
                   && pins == WORD_W'(combo_ff[g])) begin
                  matched   = 1'b1;
                  masked_in = masked_ff | WORD_W'(combo_ff[g]);
                  word      = WORD_W'(1) << (GROUP_BASE + g);
               end
            end
            if (word != accepted_ff) begin
               hold_run_in = '0;
               run_next    = change_run_ff + RUN_W'(1);
               if (run_next > debounce_ff) begin
                  change_run_in     = '0;
                  changed_in        = word ^ accepted_ff;
                  accepted_in       = word;
                  current_in        = word;
                  result.scan_event = EV_CHANGE;
               end else begin
                  change_run_in = run_next;
               end
            end else begin
               change_run_in = '0;
               if (word != '0) begin
                  run_next = hold_run_ff + RUN_W'(1);
                  if (run_next > debounce_ff) begin
                     hold_run_in       = '0;
                     current_in        = word;
                     result.scan_event = EV_HOLD;
                  end else begin
                     hold_run_in = run_next;
                  end
               end else begin
                  hold_run_in  = '0;
                  current_in   = '0;
                  masked_in    = '0;
                  repeating_in = '0;
               end
            end
         end
         REQ_QUERY: begin
            if ((masked_ff & k) != '0) begin
               result.key_action = ACT_NONE;
            end else if ((repeating_ff & k) != '0) begin
               if ((changed_ff & k) != '0) begin
                  changed_in = '0;
               end
               if ((changed_ff & k) != '0 && (current_ff & k) == '0) begin
                  result.key_action = ACT_UP;
               end else if ((current_ff & k) != '0 && first_ff == '0
                            && repeat_ff == '0) begin
                  repeat_in         = req_item.repeat_ms;
                  result.key_action = ACT_REPEAT;
               end
            end else if ((changed_ff & k) != '0) begin
               changed_in = '0;
               if ((current_ff & k) == '0) begin
                  result.key_action = ACT_UP;
               end else begin
                  result.key_action = ACT_DOWN;
                  if (req_item.no_repeat) begin
                     if (current_ff == k) begin
                        first_in  = '0;
                        repeat_in = '0;
                     end
                  end else begin
                     repeating_in = repeating_ff | k;
                     first_in     = req_item.first_delay_ms;
                     repeat_in    = '0;
                  end
               end
            end
         end
         REQ_MASK: begin
            masked_in = masked_ff | k;
         end
         REQ_RECAPTURE: begin
            accepted_in  = accepted_ff & ~k;
            repeating_in = repeating_ff & ~k;
         end
         default: ;
      endcase
      result.key_state = current_in;
   end

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_valid_in = accept;
         out_in       = result;
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_ff   <= '0;
         changed_ff    <= '0;
         current_ff    <= '0;
         masked_ff     <= '0;
         repeating_ff  <= '0;
         first_ff      <= '0;
         repeat_ff     <= '0;
         prev_tick_ff  <= '0;
         change_run_ff <= '0;
         hold_run_ff   <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            accepted_ff   <= accepted_in;
            changed_ff    <= changed_in;
            current_ff    <= current_in;
            masked_ff     <= masked_in;
            repeating_ff  <= repeating_in;
            first_ff      <= first_in;
            repeat_ff     <= repeat_in;
            prev_tick_ff  <= prev_tick_in;
            change_run_ff <= change_run_in;
            hold_run_ff   <= hold_run_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid entry holds an item while the result register is empty.");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("An accepted item produced no result.");

   a_group_word_shape: assert property (@(posedge clock) disable iff (reset)
      $onehot0(accepted_ff[WORD_W-1:GROUP_BASE])
      && (accepted_ff[WORD_W-1:GROUP_BASE] == '0
          || accepted_ff[GROUP_BASE-1:0] == '0))
      else $error("Accepted word mixes group bits with pin bits.");

   a_one_answer_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.key_action != ACT_NONE) |-> rsp_item.scan_event == EV_NONE)
      else $error("Result carries both a key answer and a scan event.");
`endif

endmodule
